// ----- hdl/kpdc_pkg.sv -----
// Shared types and constants for the key press duration counter.
`timescale 1ns / 1ps
`default_nettype none
package kpdc_pkg;

    localparam int ROW_W   = 4;
    localparam int COL_W   = 3;
    localparam int TIME_W  = 16;
    localparam int COUNT_W = 32;
    localparam int CMD_W   = 2;

    // Full key index before trimming to the table depth (16 rows x 8 columns).
    localparam int FULL_IDX_W = ROW_W + COL_W;

    localparam logic [TIME_W-1:0] THRESHOLD_RESET = 16'd250;

    typedef enum logic [CMD_W-1:0] {
        CMD_PRESS   = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_QUERY   = 2'd2
    } cmd_t;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_UPDATE = 1'b1
    } state_t;

    // One table entry per key.
    typedef struct packed {
        logic [COUNT_W-1:0] long_count;
        logic [COUNT_W-1:0] short_count;
        logic [TIME_W-1:0]  stamp;
    } entry_t;

    // Input word, last field in the lowest bits.
    typedef struct packed {
        logic [6:0]        pad;
        logic [TIME_W-1:0] now_ms;
        logic [COL_W-1:0]  key_col;
        logic [ROW_W-1:0]  key_row;
        logic [CMD_W-1:0]  cmd;
    } in_word_t;

    // Result word, last field in the lowest bits.
    typedef struct packed {
        logic [4:0]         pad;
        logic [COUNT_W-1:0] long_total;
        logic [COUNT_W-1:0] short_total;
        logic [TIME_W-1:0]  held_ms;
        logic               was_long;
        logic               counted;
        logic               key_valid;
    } out_word_t;

    localparam int IN_WORD_W  = $bits(in_word_t);
    localparam int OUT_WORD_W = $bits(out_word_t);

endpackage
`default_nettype wire

// ----- hdl/kpdc_table.sv -----
// Per-key statistics memory with one read and one write port and reset valid bits.
`timescale 1ns / 1ps
`default_nettype none
module kpdc_table #(
    parameter int KEYS  = 60,
    parameter int IDX_W = 6
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 rd_en,
    input  wire [IDX_W-1:0]     rd_idx,
    output kpdc_pkg::entry_t    rd_entry,
    input  wire                 wr_en,
    input  wire [IDX_W-1:0]     wr_idx,
    input  wire kpdc_pkg::entry_t wr_entry
);

    kpdc_pkg::entry_t mem [KEYS];
    kpdc_pkg::entry_t rd_data_reg;
    logic             rd_hit_reg;
    logic [KEYS-1:0]  entry_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_entry;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    // An entry never written since reset reads as all zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
            rd_hit_reg      <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                entry_valid_reg[wr_idx] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_hit_reg <= entry_valid_reg[rd_idx];
            end
        end
    end

    assign rd_entry = rd_hit_reg ? rd_data_reg : '0;

endmodule
`default_nettype wire

// ----- hdl/kpdc_update.sv -----
// Modify step: measures the held time, picks the counter and forms the result word.
`timescale 1ns / 1ps
`default_nettype none
module kpdc_update (
    input  wire [kpdc_pkg::CMD_W-1:0]  cmd,
    input  wire [kpdc_pkg::TIME_W-1:0] now_ms,
    input  wire [kpdc_pkg::TIME_W-1:0] threshold,
    input  wire                        key_ok,
    input  wire kpdc_pkg::entry_t      old_entry,
    output logic                       wr_en,
    output kpdc_pkg::entry_t           new_entry,
    output kpdc_pkg::out_word_t        result
);

    logic [kpdc_pkg::TIME_W-1:0] held;
    logic                        is_long;

    assign held    = now_ms - old_entry.stamp;
    assign is_long = held >= threshold;

    always_comb
    begin
        new_entry = old_entry;
        wr_en     = 1'b0;
        result    = '0;
        case (kpdc_pkg::cmd_t'(cmd))
            kpdc_pkg::CMD_PRESS:
            begin
                new_entry.stamp = now_ms;
                wr_en           = key_ok;
            end
            kpdc_pkg::CMD_RELEASE:
            begin
                wr_en           = key_ok;
                result.counted  = key_ok;
                result.was_long = key_ok & is_long;
                result.held_ms  = key_ok ? held : '0;
                if (is_long)
                begin
                    new_entry.long_count = old_entry.long_count + 1'b1;
                end
                else
                begin
                    new_entry.short_count = old_entry.short_count + 1'b1;
                end
            end
            default:
            begin
                // Query and the unused code only report the counters.
                wr_en = 1'b0;
            end
        endcase
        result.key_valid   = key_ok;
        result.short_total = key_ok ? new_entry.short_count : '0;
        result.long_total  = key_ok ? new_entry.long_count : '0;
    end

endmodule
`default_nettype wire

// ----- hdl/key_press_duration_counter_core.sv -----
// Top level of the key press duration counter: handshakes, sequencer and result register.
`timescale 1ns / 1ps
`default_nettype none
// Keeps a press stamp and short and long release counters for every key of a
// ROWS x COLS matrix in one on-chip table. The idle state accepts a word and
// reads the key's entry; the update state then updates it, writes it back and
// loads the result register, waiting while an earlier result is untaken. The
// registered table read and the two-state sequencer, which lets only one word
// into the read-modify-write at a time, set this pace: no new word is accepted
// until the last one has left the update state. A result waiting in the output
// register does not block the next word's read. The table needs no clearing
// pass after reset: a valid bit per key makes an unwritten entry read as zero.
// The threshold register may be written at any time the block is idle.
module key_press_duration_counter_core #(
    parameter int ROWS = 10,
    parameter int COLS = 6
) (
    input  wire         clk,
    input  wire         rst_n,
    // s_tdata, lowest bit up: cmd[1:0], key_row[5:2], key_col[8:6], now_ms[24:9], zero pad
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire [31:0]  s_tdata,
    // m_tdata, lowest bit up: key_valid[0], counted[1], was_long[2], held_ms[18:3],
    // short_total[50:19], long_total[82:51], zero pad
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [87:0] m_tdata,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire [15:0]  cfg_data
);

    localparam int KEYS  = ROWS * COLS;
    localparam int IDX_W = (KEYS > 1) ? $clog2(KEYS) : 1;
    localparam int FW    = kpdc_pkg::FULL_IDX_W;

    localparam logic [kpdc_pkg::ROW_W:0] ROWS_L = (kpdc_pkg::ROW_W + 1)'(ROWS);
    localparam logic [kpdc_pkg::COL_W:0] COLS_L = (kpdc_pkg::COL_W + 1)'(COLS);
    localparam logic [FW-1:0]            COLS_F = FW'(COLS);

    kpdc_pkg::in_word_t  in_word;
    kpdc_pkg::state_t    state_reg, state_next;
    logic                in_accept;
    logic                commit;
    logic                key_ok;
    logic [FW-1:0]       full_idx;
    logic [IDX_W-1:0]    key_idx;

    logic [kpdc_pkg::CMD_W-1:0]  cmd_reg;
    logic [kpdc_pkg::TIME_W-1:0] now_reg;
    logic [IDX_W-1:0]            idx_reg;
    logic                        key_ok_reg;
    logic [kpdc_pkg::TIME_W-1:0] threshold_reg;

    logic                out_valid_reg, out_valid_next;
    kpdc_pkg::out_word_t out_data_reg;

    kpdc_pkg::entry_t    old_entry;
    kpdc_pkg::entry_t    new_entry;
    kpdc_pkg::out_word_t result;
    logic                wr_en;

    assign in_word  = kpdc_pkg::in_word_t'(s_tdata);
    assign key_ok   = ({1'b0, in_word.key_row} < ROWS_L) && ({1'b0, in_word.key_col} < COLS_L);
    assign full_idx = FW'(in_word.key_row) * COLS_F + FW'(in_word.key_col);
    assign key_idx  = full_idx[IDX_W-1:0];

    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            kpdc_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = kpdc_pkg::ST_UPDATE;
                end
            end
            kpdc_pkg::ST_UPDATE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = kpdc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = kpdc_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        s_tready = 1'b0;
        commit   = 1'b0;
        unique case (state_reg)
            kpdc_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            kpdc_pkg::ST_UPDATE:
            begin
                commit = !out_valid_reg || m_tready;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kpdc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            key_ok_reg    <= 1'b0;
            threshold_reg <= kpdc_pkg::THRESHOLD_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (in_accept)
            begin
                key_ok_reg <= key_ok;
            end
            if (cfg_valid && cfg_ready)
            begin
                threshold_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg <= in_word.cmd;
            now_reg <= in_word.now_ms;
            idx_reg <= key_idx;
        end
        if (commit)
        begin
            out_data_reg <= result;
        end
    end

    kpdc_table #(
        .KEYS  (KEYS),
        .IDX_W (IDX_W)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (in_accept && key_ok),
        .rd_idx   (key_idx),
        .rd_entry (old_entry),
        .wr_en    (commit && wr_en),
        .wr_idx   (idx_reg),
        .wr_entry (new_entry)
    );

    kpdc_update u_update (
        .cmd       (cmd_reg),
        .now_ms    (now_reg),
        .threshold (threshold_reg),
        .key_ok    (key_ok_reg),
        .old_entry (old_entry),
        .wr_en     (wr_en),
        .new_entry (new_entry),
        .result    (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // An accepted word always moves on to its update cycle.
    a_accept_to_update: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> state_reg == kpdc_pkg::ST_UPDATE)
        else $error("accepted word did not reach the update cycle");

    // Table writes only happen for a key inside the matrix.
    a_write_in_matrix: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && wr_en) |-> key_ok_reg)
        else $error("table written for a key outside the matrix");

    // A counted release always belongs to a valid key.
    a_counted_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && result.counted) |-> result.key_valid)
        else $error("counted release without a valid key");

    // With nothing being updated, a taken result is not followed by another.
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && state_reg == kpdc_pkg::ST_IDLE) |=> !m_tvalid)
        else $error("result appeared without an update");

endmodule
`default_nettype wire
